// File: design/assert_macros.svh
// Assertion macros shared by the packet builder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a property in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: design/tspb_pkg.sv
// Shared types and constants for the transport stream packet builder.
`timescale 1ns / 1ps
package tspb_pkg;

	localparam int PcrW     = 42;
	localparam int PidW     = 13;
	localparam int CcW      = 4;
	localparam int WordW    = 32;
	localparam int IdxW     = 6;
	localparam int BaseW    = 33;
	localparam int ExtW     = 9;
	localparam int PktWords = 47;
	localparam int DivCntW  = 1;
	localparam int FifoDepth = 2;
	localparam int FifoAw    = 1;
	localparam int FifoCntW  = 2;

	// pcr/4 is split into two 20-bit halves for the divide by 75
	localparam int PcrHiW     = 20;
	localparam int PcrLoW     = 20;
	localparam int SumW       = 21;
	localparam int HiProdW    = 34;
	localparam int RecipW     = 22;
	localparam int RecipProdW = 43;
	localparam int RecipShift = 28;
	localparam int QuoW       = 15;
	localparam int ModW       = 7;

	localparam logic [IdxW-1:0]    LastIdx      = IdxW'(PktWords - 1);
	localparam logic [DivCntW-1:0] DivLast      = 1'b1;
	localparam logic [ExtW:0]      PcrDiv       = 10'd300;
	localparam logic [13:0]        HiScale      = 14'd13981;
	localparam logic [RecipW-1:0]  RecipM       = 22'd3579140;
	localparam logic [ModW-1:0]    ModDiv       = 7'd75;
	localparam logic [7:0]         SyncByte     = 8'h47;
	localparam logic [7:0]         FillByte     = 8'hFF;
	localparam logic [7:0]         AdaptLen     = 8'd183;
	localparam logic [7:0]         AdaptPcrFlag = 8'h10;
	localparam logic [5:0]         PcrReserved  = 6'h3F;
	localparam logic [PidW-1:0]    NullPid      = 13'h1FFF;
	localparam logic [1:0]         AfcPayload   = 2'b01;
	localparam logic [1:0]         AfcAdapt     = 2'b10;

	typedef enum logic {
		CMD_NULL = 1'b0,
		CMD_PCR  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_DIV,
		FE_PUSH
	} fe_state_t;

	typedef struct packed {
		cmd_t            cmd;
		logic [PidW-1:0] pid;
		logic [CcW-1:0]  cc;
		logic [BaseW-1:0] base;
		logic [ExtW-1:0] ext;
	} qentry_t;

endpackage

// File: design/ts_null_and_pcr_packet_builder.sv
// Top level of the MPEG-2 transport stream null and PCR packet builder.
`timescale 1ns / 1ps
// Usage:
//   Request channel: drive cmd, pid, pcr and counter_in with start high; the
//   request is taken at a rising edge where start is high and busy is low.
//   cmd 0 builds a null packet, cmd 1 a PCR-only adaptation packet.
//   Result channel: each packet leaves as 47 big-endian 32-bit words, one per
//   cycle, each marked by strobe for one cycle with word_index, last_word on
//   word 46 and counter_next (same on every word).
// Path: with the emitter idle, a null request goes from the intake registers
//   into the queue, is popped into the emitter and leaves through its output
//   registers. A PCR request first passes the intake divider, which splits
//   pcr into base and extension by reciprocal multiplication.
// Throughput: the emitter sends one word per cycle, and queued packets follow
//   with no gap. Intake takes a new request only after it has pushed the last
//   one into the queue; busy is high while intake holds a request, also while
//   it waits on a full queue.
// Reset: arst_n clears intake, queue and emitter; no request is pending and
//   strobe is low. The receiver cannot stall: words are never held back.
module ts_null_and_pcr_packet_builder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        cmd,
	input  logic [tspb_pkg::PidW-1:0]   pid,
	input  logic [tspb_pkg::PcrW-1:0]   pcr,
	input  logic [tspb_pkg::CcW-1:0]    counter_in,
	output logic                        strobe,
	output logic [tspb_pkg::WordW-1:0]  data_word,
	output logic [tspb_pkg::IdxW-1:0]   word_index,
	output logic                        last_word,
	output logic [tspb_pkg::CcW-1:0]    counter_next
);
	import tspb_pkg::*;

	logic    push;
	qentry_t push_data;
	logic    full;
	logic    pop;
	qentry_t head;
	logic    empty;

	tspb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.pid        (pid),
		.pcr        (pcr),
		.counter_in (counter_in),
		.push       (push),
		.push_data  (push_data),
		.full       (full)
	);

	tspb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	tspb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.strobe       (strobe),
		.data_word    (data_word),
		.word_index   (word_index),
		.last_word    (last_word),
		.counter_next (counter_next)
	);

endmodule

// File: design/tspb_front.sv
// Request intake and multi-cycle PCR split into base and extension.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tspb_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       cmd,
	input  logic [tspb_pkg::PidW-1:0]  pid,
	input  logic [tspb_pkg::PcrW-1:0]  pcr,
	input  logic [tspb_pkg::CcW-1:0]   counter_in,
	output logic                       push,
	output tspb_pkg::qentry_t          push_data,
	input  logic                       full
);
	import tspb_pkg::*;

	fe_state_t             state_q, state_next;
	logic                  accept;
	logic                  div_done;
	cmd_t                  cmd_q;
	logic [PidW-1:0]       pid_q;
	logic [CcW-1:0]        cc_q;
	logic [DivCntW-1:0]    cnt_q;
	logic [PcrHiW-1:0]     pcr_hi;
	logic [PcrLoW-1:0]     pcr_lo;
	logic [HiProdW-1:0]    hi_prod_q;
	logic [SumW-1:0]       sum_q;
	logic [1:0]            low2_q;
	logic [QuoW-1:0]       quo_q;
	logic [BaseW-1:0]      base_q;
	logic [ExtW-1:0]       ext_q;
	logic [RecipProdW-1:0] recip_prod;
	logic [HiProdW-1:0]    base_full;
	logic [2*ModW-1:0]     mod_prod;
	logic [ModW-1:0]       mod_rem;

	assign accept   = start && !busy;
	assign div_done = (cnt_q == DivLast);

	// pcr/300 = (pcr/4)/75; since 2^20 = 75*13981 + 1, the high half contributes
	// hi*13981 to the quotient and only hi + lo needs a true divide by 75
	assign pcr_hi = pcr[PcrW-1 -: PcrHiW];
	assign pcr_lo = pcr[2 +: PcrLoW];

	// scaled reciprocal of 75 is exact for sums below 2^21
	assign recip_prod = RecipProdW'(sum_q) * RecipProdW'(RecipM);
	assign base_full  = hi_prod_q + HiProdW'(quo_q);
	assign mod_prod   = (2*ModW)'(quo_q[ModW-1:0]) * (2*ModW)'(ModDiv);
	assign mod_rem    = sum_q[ModW-1:0] - mod_prod[ModW-1:0];

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			FE_IDLE: begin
				if (accept) begin
					state_next = (cmd_t'(cmd) == CMD_PCR) ? FE_DIV : FE_PUSH;
				end
			end
			FE_DIV: begin
				if (div_done) begin
					state_next = FE_PUSH;
				end
			end
			FE_PUSH: begin
				if (!full) begin
					state_next = FE_IDLE;
				end
			end
			default: state_next = FE_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b1;
		push = 1'b0;
		unique case (state_q)
			FE_IDLE: busy = 1'b0;
			FE_DIV:  busy = 1'b1;
			FE_PUSH: push = !full;
			default: busy = 1'b1;
		endcase
	end

	assign push_data.cmd  = cmd_q;
	assign push_data.pid  = pid_q;
	assign push_data.cc   = cc_q;
	assign push_data.base = base_q;
	assign push_data.ext  = ext_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd_t'(cmd);
			pid_q     <= pid;
			cc_q      <= counter_in;
			hi_prod_q <= HiProdW'(pcr_hi) * HiProdW'(HiScale);
			sum_q     <= SumW'(pcr_hi) + SumW'(pcr_lo);
			low2_q    <= pcr[1:0];
			cnt_q     <= '0;
		end else if (state_q == FE_DIV) begin
			cnt_q <= cnt_q + DivCntW'(1);
			if (div_done) begin
				base_q <= base_full[BaseW-1:0];
				ext_q  <= {mod_rem, low2_q};
			end else begin
				quo_q <= recip_prod[RecipShift +: QuoW];
			end
		end
	end

	`ASSERT_NEXT(a_div_to_push, (state_q == FE_DIV) && div_done, state_q == FE_PUSH,
		"front: divider did not hand off after the last step")

endmodule

// File: design/tspb_fifo.sv
// Two-entry request queue between intake and word emitter.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tspb_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tspb_pkg::qentry_t push_data,
	output logic              full,
	input  logic              pop,
	output tspb_pkg::qentry_t head,
	output logic              empty
);
	import tspb_pkg::*;

	qentry_t             mem_q [FifoDepth];
	logic [FifoAw-1:0]   wr_ptr_q;
	logic [FifoAw-1:0]   rd_ptr_q;
	logic [FifoCntW-1:0] count_q;

	assign full  = (count_q == FifoCntW'(FifoDepth));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FifoAw'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FifoAw'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + FifoCntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FifoCntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`ASSERT_CLK(a_no_overflow, !(push && full), "queue: request pushed while full")
	`ASSERT_CLK(a_no_underflow, !(pop && empty), "queue: request popped while empty")

endmodule

// File: design/tspb_back.sv
// Word emitter: walks the 47 packet words of each queued request.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tspb_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tspb_pkg::qentry_t           head,
	input  logic                        empty,
	output logic                        pop,
	output logic                        strobe,
	output logic [tspb_pkg::WordW-1:0]  data_word,
	output logic [tspb_pkg::IdxW-1:0]   word_index,
	output logic                        last_word,
	output logic [tspb_pkg::CcW-1:0]    counter_next
);
	import tspb_pkg::*;

	qentry_t          cur_q;
	logic             active_q;
	logic [IdxW-1:0]  idx_q;
	logic             at_last;
	logic [PidW-1:0]  hdr_pid;
	logic [1:0]       hdr_afc;
	logic [WordW-1:0] word;
	logic [CcW-1:0]   cc_after;

	logic             strobe_q;
	logic [WordW-1:0] data_q;
	logic [IdxW-1:0]  index_q;
	logic             last_q;
	logic [CcW-1:0]   cc_q;

	assign at_last = (idx_q == LastIdx);
	// take the next request right as the current packet ends
	assign pop     = !empty && (!active_q || at_last);

	assign hdr_pid  = (cur_q.cmd == CMD_PCR) ? cur_q.pid : NullPid;
	assign hdr_afc  = (cur_q.cmd == CMD_PCR) ? AfcAdapt : AfcPayload;
	assign cc_after = (cur_q.cmd == CMD_PCR) ? cur_q.cc : cur_q.cc + CcW'(1);

	always_comb begin
		word = {4{FillByte}};
		case (idx_q)
			IdxW'(0): begin
				word = {SyncByte, 3'b000, hdr_pid, 2'b00, hdr_afc, cur_q.cc};
			end
			IdxW'(1): begin
				if (cur_q.cmd == CMD_PCR) begin
					word = {AdaptLen, AdaptPcrFlag, cur_q.base[32:17]};
				end
			end
			IdxW'(2): begin
				if (cur_q.cmd == CMD_PCR) begin
					word = {cur_q.base[16:0], PcrReserved, cur_q.ext};
				end
			end
			default: word = {4{FillByte}};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (active_q) begin
				idx_q <= idx_q + IdxW'(1);
				if (at_last) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		data_q  <= word;
		index_q <= idx_q;
		last_q  <= active_q && at_last;
		cc_q    <= cc_after;
	end

	assign strobe       = strobe_q;
	assign data_word    = data_q;
	assign word_index   = index_q;
	assign last_word    = last_q;
	assign counter_next = cc_q;

	`ASSERT_NEXT(a_packet_contiguous, strobe_q && !last_q, strobe_q,
		"back: packet words not contiguous")

endmodule

// File: tb/ts_packet_word_checker.sv
// Predicts the packet words of each accepted request and checks the words that come out.
`timescale 1ns / 1ps
module ts_packet_word_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic                        cmd,
	input  logic [tspb_pkg::PidW-1:0]   pid,
	input  logic [tspb_pkg::PcrW-1:0]   pcr,
	input  logic [tspb_pkg::CcW-1:0]    counter_in,
	input  logic                        strobe,
	input  logic [tspb_pkg::WordW-1:0]  data_word,
	input  logic [tspb_pkg::IdxW-1:0]   word_index,
	input  logic                        last_word,
	input  logic [tspb_pkg::CcW-1:0]    counter_next,
	output int                          mismatches,
	output int                          words_pending
);
	import tspb_pkg::*;

	typedef struct packed {
		logic [WordW-1:0] data;
		logic [IdxW-1:0]  idx;
		logic             last;
		logic [CcW-1:0]   ccn;
	} packet_word_t;

	packet_word_t expected_words[$];
	int           err_cnt;

	// Lay out the 188 packet bytes, then queue them as 47 big-endian words.
	task automatic predict_packet(input logic kind, input logic [PidW-1:0] pid_v,
			input logic [PcrW-1:0] pcr_v, input logic [CcW-1:0] cc);
		logic [7:0]       pkt [0:PktWords*4-1];
		logic [PcrW-1:0]  quot;
		logic [BaseW-1:0] base;
		logic [ExtW-1:0]  ext;
		logic [CcW-1:0]   ccn;
		packet_word_t     w;
		int               i;
		for (i = 0; i < PktWords * 4; i++)
			pkt[i] = FillByte;
		pkt[0] = SyncByte;
		if (kind == CMD_NULL) begin
			pkt[1] = {3'b000, NullPid[12:8]};
			pkt[2] = NullPid[7:0];
			pkt[3] = {2'b00, AfcPayload, cc};
			ccn = cc + 4'd1;
		end else begin
			// base keeps only its low 33 bits; the extension is always pcr mod 300
			quot = pcr_v / PcrW'(PcrDiv);
			base = quot[BaseW-1:0];
			ext  = ExtW'(pcr_v % PcrW'(PcrDiv));
			pkt[1]  = {3'b000, pid_v[12:8]};
			pkt[2]  = pid_v[7:0];
			pkt[3]  = {2'b00, AfcAdapt, cc};
			pkt[4]  = AdaptLen;
			pkt[5]  = AdaptPcrFlag;
			pkt[6]  = base[32:25];
			pkt[7]  = base[24:17];
			pkt[8]  = base[16:9];
			pkt[9]  = base[8:1];
			pkt[10] = {base[0], PcrReserved, ext[8]};
			pkt[11] = ext[7:0];
			ccn = cc;
		end
		for (i = 0; i < PktWords; i++) begin
			w.data = {pkt[4*i], pkt[4*i+1], pkt[4*i+2], pkt[4*i+3]};
			w.idx  = IdxW'(i);
			w.last = (i == PktWords - 1);
			w.ccn  = ccn;
			expected_words.push_back(w);
		end
	endtask

	task automatic note_mismatch(input string what, input logic [WordW-1:0] exp_v,
			input logic [WordW-1:0] act_v);
		err_cnt++;
		$display("%0t: %s expected %0h actual %0h", $time, what, exp_v, act_v);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		packet_word_t e;
		if (!arst_n) begin
			expected_words.delete();
			err_cnt = 0;
			mismatches <= 0;
			words_pending <= 0;
		end else begin
			if (strobe) begin
				if (expected_words.size() == 0) begin
					err_cnt++;
					$display("%0t: word expected none actual data %0h index %0d",
						$time, data_word, word_index);
				end else begin
					e = expected_words.pop_front();
					if (data_word !== e.data)
						note_mismatch($sformatf("word %0d data_word", e.idx), e.data,
							data_word);
					if (word_index !== e.idx)
						note_mismatch("word_index", WordW'(e.idx), WordW'(word_index));
					if (last_word !== e.last)
						note_mismatch($sformatf("word %0d last_word", e.idx),
							WordW'(e.last), WordW'(last_word));
					if (counter_next !== e.ccn)
						note_mismatch($sformatf("word %0d counter_next", e.idx),
							WordW'(e.ccn), WordW'(counter_next));
				end
			end
			if (start && !busy)
				predict_packet(cmd, pid, pcr, counter_in);
			mismatches <= err_cnt;
			words_pending <= expected_words.size();
		end
	end

endmodule

// File: tb/ts_null_and_pcr_packet_builder_tb.sv
// Testbench top: drives packet requests into the builder and reports the verdict.
`timescale 1ns / 1ps
module ts_null_and_pcr_packet_builder_tb;
	import tspb_pkg::*;

	localparam logic [PcrW-1:0] PcrTop  = 42'd2576980377599;
	localparam logic [PcrW-1:0] PcrWrap = 42'd2576980377600;
	localparam logic [PcrW-1:0] PcrOnes = {PcrW{1'b1}};

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              cmd;
	logic [PidW-1:0]   pid;
	logic [PcrW-1:0]   pcr;
	logic [CcW-1:0]    counter_in;
	logic              strobe;
	logic [WordW-1:0]  data_word;
	logic [IdxW-1:0]   word_index;
	logic              last_word;
	logic [CcW-1:0]    counter_next;
	int                mismatches;
	int                words_pending;

	ts_null_and_pcr_packet_builder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.pid          (pid),
		.pcr          (pcr),
		.counter_in   (counter_in),
		.strobe       (strobe),
		.data_word    (data_word),
		.word_index   (word_index),
		.last_word    (last_word),
		.counter_next (counter_next)
	);

	ts_packet_word_checker packet_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.pid           (pid),
		.pcr           (pcr),
		.counter_in    (counter_in),
		.strobe        (strobe),
		.data_word     (data_word),
		.word_index    (word_index),
		.last_word     (last_word),
		.counter_next  (counter_next),
		.mismatches    (mismatches),
		.words_pending (words_pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Hold the request until the edge that takes it.
	task automatic send_request(input cmd_t kind, input logic [PidW-1:0] pid_v,
			input logic [PcrW-1:0] pcr_v, input logic [CcW-1:0] cc);
		start      <= 1'b1;
		cmd        <= kind;
		pid        <= pid_v;
		pcr        <= pcr_v;
		counter_in <= cc;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Drop start for a random number of cycles; fields churn while idle.
	task automatic idle_gap(input int pct);
		logic [63:0] junk;
		while ($urandom_range(99) < pct) begin
			junk = {$urandom(), $urandom()};
			start      <= 1'b0;
			cmd        <= junk[0];
			pid        <= junk[13:1];
			pcr        <= junk[55:14];
			counter_in <= junk[59:56];
			@(posedge clk);
		end
	endtask

	task automatic send_random;
		logic [63:0]     r;
		logic [PcrW-1:0] pcr_v;
		cmd_t            kind;
		r = {$urandom(), $urandom()};
		case ($urandom_range(5))
			0: pcr_v = PcrW'($urandom_range(1000));
			1: pcr_v = PcrTop - PcrW'($urandom_range(600));
			2: pcr_v = PcrWrap + PcrW'($urandom_range(600));
			3: pcr_v = PcrOnes - PcrW'($urandom_range(600));
			default: pcr_v = r[PcrW-1:0];
		endcase
		kind = $urandom_range(1) ? CMD_PCR : CMD_NULL;
		send_request(kind, PidW'($urandom()), pcr_v, CcW'($urandom()));
	endtask

	task automatic wait_drained;
		@(posedge clk);
		while (words_pending != 0)
			@(posedge clk);
	endtask

	initial begin
		#5_000_000;
		$display("ts_null_and_pcr_packet_builder regression: fail");
		$finish;
	end

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = CMD_NULL;
		pid        = '0;
		pcr        = '0;
		counter_in = '0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(CMD_NULL, 13'h0000, 42'd0, 4'd0);
		send_request(CMD_NULL, 13'h1FFF, PcrOnes, 4'd15);
		send_request(CMD_NULL, 13'h1555, 42'h2AA_AAAA_AAAA, 4'd7);
		send_request(CMD_PCR, 13'h0000, 42'd0, 4'd0);
		send_request(CMD_PCR, 13'h1FFF, PcrTop, 4'd15);
		send_request(CMD_PCR, 13'h0100, 42'd299, 4'd3);
		send_request(CMD_PCR, 13'h1FFF, 42'd300, 4'd8);
		send_request(CMD_PCR, 13'h0001, PcrWrap, 4'd1);
		send_request(CMD_PCR, 13'h0AAA, PcrOnes, 4'd14);
		send_request(CMD_PCR, 13'h0AAA, 42'h2AA_AAAA_AAAA, 4'd10);
		send_request(CMD_PCR, 13'h1555, 42'h155_5555_5555, 4'd5);
		send_request(CMD_NULL, 13'h0000, 42'd0, 4'd15);
		send_request(CMD_PCR, 13'h1000, 42'd8_589_934_591, 4'd9);
		start <= 1'b0;

		// hold off until every word of the directed packets is out
		wait_drained();
		repeat (8)
			@(posedge clk);

		for (int phase = 0; phase < 3; phase++) begin
			for (int n = 0; n < 117; n++) begin
				idle_gap(phase == 0 ? 30 : (phase == 1 ? 88 : 0));
				send_random();
			end
		end
		start <= 1'b0;

		wait_drained();
		repeat (60)
			@(posedge clk);
		if (mismatches == 0 && words_pending == 0)
			$display("ts_null_and_pcr_packet_builder regression: pass");
		else
			$display("ts_null_and_pcr_packet_builder regression: fail");
		$finish;
	end

endmodule
